// ===== design/buddy_page_allocator_macros.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int ORD_W  = 4;   // order field width
    localparam int PAGE_W = 12;  // page field width of the words
    localparam int CNT_W  = 13;  // page_count register width

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ORD_W-1:0]  order;
        logic [PAGE_W-1:0] page;
    } t_cmd;

    typedef struct packed {
        logic [PAGE_W-1:0] block_page;
        logic              status;
    } t_result;

    // per-field write enables of the page table
    typedef struct packed {
        logic busy;
        logic order;
        logic next;
        logic prev;
    } t_wmask;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_RD_U,
        S_WAIT_U,
        S_FRD,
        S_FWAIT,
        S_MCHK,
        S_UL_BUSY,
        S_UL_PREV,
        S_UL_NEXT,
        S_SPLIT,
        S_PUSH_ENT,
        S_PUSH_LINK,
        S_DONE
    } t_state;

endpackage

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Page table: busy, order and list links per page; field write mask.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int LW    = 13
) (
    input  logic                 i_clk,
    input  bpa_pkg::t_wmask      i_wmask,
    input  logic [AW-1:0]        i_waddr,
    input  logic                 i_wbusy,
    input  logic [bpa_pkg::ORD_W-1:0] i_worder,
    input  logic [LW-1:0]        i_wnext,
    input  logic [LW-1:0]        i_wprev,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic                 o_rbusy,
    output logic [bpa_pkg::ORD_W-1:0] o_rorder,
    output logic [LW-1:0]        o_rnext,
    output logic [LW-1:0]        o_rprev
);
    import bpa_pkg::*;

    logic             mem_busy  [DEPTH];
    logic [ORD_W-1:0] mem_order [DEPTH];
    logic [LW-1:0]    mem_next  [DEPTH];
    logic [LW-1:0]    mem_prev  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wmask.busy)  mem_busy[i_waddr]  <= i_wbusy;
        if (i_wmask.order) mem_order[i_waddr] <= i_worder;
        if (i_wmask.next)  mem_next[i_waddr]  <= i_wnext;
        if (i_wmask.prev)  mem_prev[i_waddr]  <= i_wprev;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rbusy  <= mem_busy[i_raddr];
            o_rorder <= mem_order[i_raddr];
            o_rnext  <= mem_next[i_raddr];
            o_rprev  <= mem_prev[i_raddr];
        end
    end

endmodule

// ===== design/bpa_seq.sv =====
// ----------------------------------------------------------------------------
// bpa_seq
// Command sequencer: list heads, search, unlink, split and merge steps.
// ----------------------------------------------------------------------------
module bpa_seq #(
    parameter int ORDER_COUNT = 11,
    parameter int MAX_PAGES   = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  bpa_pkg::t_cmd             i_cmd,
    input  logic [bpa_pkg::CNT_W-1:0] i_cnt,
    output logic                      o_done,
    output bpa_pkg::t_result          o_result
);
    import bpa_pkg::*;

    localparam int LW = $clog2(MAX_PAGES + 1);
    localparam int AW = $clog2(MAX_PAGES);
    localparam int PW = (LW > ORDER_COUNT) ? LW : ORDER_COUNT;
    localparam int SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int HW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
    localparam logic [LW-1:0]    NIL    = LW'(MAX_PAGES);
    localparam logic [PW-1:0]    LAST   = PW'(MAX_PAGES - 1);
    localparam logic [PW-1:0]    LIMIT  = PW'(MAX_PAGES);
    localparam logic [ORD_W:0]   OC     = (ORD_W + 1)'(ORDER_COUNT);

    t_state r_state, n_state;
    logic              r_cmd, n_cmd;
    logic [ORD_W-1:0]  r_want, n_want;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [PW-1:0]     r_pg, n_pg;
    logic [PW-1:0]     r_u, n_u;
    logic [LW-1:0]     r_p, n_p;
    logic [LW-1:0]     r_n, n_n;
    logic [LW-1:0]     r_head [ORDER_COUNT];
    logic              head_we;
    logic [LW-1:0]     head_wdata;
    logic [PAGE_W-1:0] r_res_page, n_res_page;
    logic              r_res_fail, n_res_fail;

    t_wmask            wmask;
    logic [AW-1:0]     waddr;
    logic              wbusy;
    logic [ORD_W-1:0]  worder;
    logic [LW-1:0]     wnext;
    logic [LW-1:0]     wprev;
    logic              re;
    logic [AW-1:0]     raddr;
    logic              rbusy;
    logic [ORD_W-1:0]  rorder;
    logic [LW-1:0]     rnext;
    logic [LW-1:0]     rprev;

    bpa_ram #(.DEPTH(MAX_PAGES), .AW(AW), .LW(LW)) u_ram (
        .i_clk   (i_clk),
        .i_wmask (wmask),
        .i_waddr (waddr),
        .i_wbusy (wbusy),
        .i_worder(worder),
        .i_wnext (wnext),
        .i_wprev (wprev),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rbusy (rbusy),
        .o_rorder(rorder),
        .o_rnext (rnext),
        .o_rprev (rprev)
    );

    // helpers
    logic [LW-1:0]    head_k;
    logic             head_nil;
    logic             k_in;
    logic             k_last;
    logic [PW-1:0]    size_m;
    logic [PW-1:0]    b_m;
    logic             b_fits;
    logic [ORD_W-1:0] km1;
    logic [PW-1:0]    b_s;
    logic             accept;
    logic             free_ok;

    assign k_in     = {1'b0, r_k} < OC;
    assign head_k   = k_in ? r_head[r_k[HW-1:0]] : NIL;
    assign head_nil = (head_k == NIL);
    assign k_last   = ({1'b0, r_k} + (ORD_W + 1)'(1)) >= OC;
    assign size_m   = PW'(1) << r_k;
    assign b_m      = r_pg ^ size_m;
    assign b_fits   = (SW'(b_m) + SW'(size_m)) <= SW'(i_cnt);
    assign km1      = r_k - ORD_W'(1);
    assign b_s      = r_pg ^ (PW'(1) << km1);
    assign accept   = i_start && (r_state == S_IDLE);
    assign free_ok  = (32'(i_cmd.order) < ORDER_COUNT) && (32'(i_cmd.page) < MAX_PAGES);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_u == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.command == CMD_ALLOC) n_state = S_SEARCH;
                    else if (free_ok)               n_state = S_FRD;
                    else                            n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                if (!k_in)          n_state = S_DONE;
                else if (!head_nil) n_state = S_RD_U;
            end
            S_RD_U:      n_state = S_WAIT_U;
            S_WAIT_U: begin
                if (r_cmd == CMD_ALLOC)          n_state = S_UL_BUSY;
                else if (rbusy || rorder != r_k) n_state = S_PUSH_ENT;
                else                             n_state = S_UL_BUSY;
            end
            S_FRD:       n_state = S_FWAIT;
            S_FWAIT:     n_state = rbusy ? S_MCHK : S_DONE;
            S_MCHK:      n_state = (!k_last && b_fits) ? S_RD_U : S_PUSH_ENT;
            S_UL_BUSY:   n_state = S_UL_PREV;
            S_UL_PREV:   n_state = S_UL_NEXT;
            S_UL_NEXT:   n_state = (r_cmd == CMD_ALLOC) ? S_SPLIT : S_MCHK;
            S_SPLIT: begin
                if (r_k > r_want) begin
                    if (b_s < LIMIT) n_state = S_PUSH_ENT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUSH_ENT:  n_state = S_PUSH_LINK;
            S_PUSH_LINK: n_state = (r_cmd == CMD_ALLOC) ? S_SPLIT : S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd      = r_cmd;
        n_want     = r_want;
        n_k        = r_k;
        n_pg       = r_pg;
        n_u        = r_u;
        n_p        = r_p;
        n_n        = r_n;
        n_res_page = r_res_page;
        n_res_fail = r_res_fail;
        head_we    = 1'b0;
        head_wdata = r_n;
        wmask      = '0;
        waddr      = AW'(r_u);
        wbusy      = 1'b1;
        worder     = r_k;
        wnext      = r_n;
        wprev      = r_p;
        re         = 1'b0;
        raddr      = AW'(r_u);
        unique case (r_state)
            S_CLEAR: begin
                wmask.busy = 1'b1;
                n_u        = r_u + PW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = i_cmd.command;
                    n_want     = i_cmd.order;
                    n_k        = i_cmd.order;
                    n_pg       = PW'(i_cmd.page);
                    n_res_page = '0;
                    n_res_fail = 1'b0;
                end
            end
            S_SEARCH: begin
                if (!k_in) begin
                    n_res_fail = 1'b1;
                end else if (!head_nil) begin
                    n_pg = PW'(head_k);
                    n_u  = PW'(head_k);
                end else begin
                    n_k = r_k + ORD_W'(1);
                end
            end
            S_RD_U:  re = 1'b1;
            S_WAIT_U: begin
                n_p = rprev;
                n_n = rnext;
                if (r_cmd == CMD_FREE && (rbusy || rorder != r_k)) n_u = r_pg;
            end
            S_FRD: begin
                re    = 1'b1;
                raddr = AW'(r_pg);
            end
            S_FWAIT: ;
            S_MCHK:  n_u = (!k_last && b_fits) ? b_m : r_pg;
            S_UL_BUSY: wmask.busy = 1'b1;
            S_UL_PREV: begin
                if (r_p != NIL) begin
                    wmask.next = 1'b1;
                    waddr      = AW'(r_p);
                end else begin
                    head_we = 1'b1;
                end
            end
            S_UL_NEXT: begin
                if (r_n != NIL) begin
                    wmask.prev = 1'b1;
                    waddr      = AW'(r_n);
                end
                if (r_cmd == CMD_FREE) begin
                    n_k = r_k + ORD_W'(1);
                    if (r_u < r_pg) n_pg = r_u;
                end
            end
            S_SPLIT: begin
                if (r_k > r_want) begin
                    n_k = km1;
                    n_u = b_s;
                end else begin
                    n_res_page = PAGE_W'(r_pg);
                end
            end
            S_PUSH_ENT: begin
                wmask  = '1;
                wbusy  = 1'b0;
                wnext  = head_k;
                wprev  = NIL;
            end
            S_PUSH_LINK: begin
                if (!head_nil) begin
                    wmask.prev = 1'b1;
                    waddr      = AW'(head_k);
                    wprev      = LW'(r_u);
                end
                head_we    = 1'b1;
                head_wdata = LW'(r_u);
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_u     <= '0;
            for (int i = 0; i < ORDER_COUNT; i++) r_head[i] <= NIL;
        end else begin
            r_state <= n_state;
            r_u     <= n_u;
            if (head_we) r_head[r_k[HW-1:0]] <= head_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_want     <= n_want;
        r_k        <= n_k;
        r_pg       <= n_pg;
        r_p        <= n_p;
        r_n        <= n_n;
        r_res_page <= n_res_page;
        r_res_fail <= n_res_fail;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_result.block_page = r_res_page;
    assign o_result.status     = r_res_fail;

endmodule

// ===== design/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator for one memory node, page table held in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_cmd and raise start; the word is taken at an edge
//   where start is high and busy is low. One command is worked at a time; the
//   next word can be taken in the cycle after the result word.
//   Result channel: o_done is high for exactly one cycle with o_result; there
//   is no back-pressure, the receiver must take the word in that cycle.
//   Config channel: i_cfg_valid/o_cfg_ready write page_count (ready is always
//   high); write it only while busy is low.
// Steps from accept edge to result edge (every page table access is a RAM step):
//   alloc: s = empty orders searched, d = split steps, p = split-off blocks
//   pushed (p = d unless a buddy lies past the node); a failed search stops
//   after the s empty orders. free: m = merges, plus a buddy read when that
//   read ends the merge. An out-of-range free skips the page table, and a
//   double free ends after reading the page. The RAM has a single write port
//   and a registered read.
// Reset: synchronous, active low. All lists are emptied at once, then a clear
//   pass marks every page busy, one page per cycle with busy high; page_count
//   returns to 4096 (clamped to MAX_PAGES).
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int ORDER_COUNT = 11,
    parameter int MAX_PAGES   = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bpa_pkg::t_cmd             i_cmd,
    output logic                      o_done,
    output bpa_pkg::t_result          o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bpa_pkg::CNT_W-1:0] i_cfg_data
);
    import bpa_pkg::*;

`include "buddy_page_allocator_macros.svh"

    // reset value of page_count, already clamped to the node size
    localparam logic [CNT_W-1:0] CNT_RST = (MAX_PAGES < 4096) ? CNT_W'(MAX_PAGES) : CNT_W'(4096);

    // clamped page_count; merging never looks past this
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cfg_valid) begin
            if (32'(i_cfg_data) > MAX_PAGES) n_cnt = CNT_W'(MAX_PAGES);
            else                             n_cnt = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_RST;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    bpa_seq #(.ORDER_COUNT(ORDER_COUNT), .MAX_PAGES(MAX_PAGES)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_cmd   (i_cmd),
        .i_cnt   (r_cnt),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // a taken command keeps the block busy until its result word
    `BPA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted command did not raise busy")
    // the block is idle again right after a result word
    `BPA_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !busy, "block still busy after result word")
    // failure reports page zero
    `BPA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && o_result.status, o_result.block_page == 0, "failed alloc returned a page")

endmodule
